@@ rtl/core/pfrl_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the packet filter and rate limiter.
// Used by every module under rtl/core; depends on nothing.
package pfrl_pkg;

    // Default table depth for the block, watch and rate tables.
    localparam int unsigned TABLE_ENTRIES_DEF = 1024;

    // Number of socket queues that exist.
    localparam int unsigned QUEUE_COUNT = 64;

    // Action codes carried in the input tuser.
    localparam logic [1:0] ACT_CLASSIFY = 2'd0;
    localparam logic [1:0] ACT_BLOCK    = 2'd1;
    localparam logic [1:0] ACT_WATCH    = 2'd2;
    localparam logic [1:0] ACT_IGNORE   = 2'd3;

    // Address family tags.
    localparam logic [1:0] FAM_NONE = 2'd0;
    localparam logic [1:0] FAM_IPV4 = 2'd1;
    localparam logic [1:0] FAM_IPV6 = 2'd2;

    // Ethertypes and protocol numbers.
    localparam logic [15:0] ETH_IPV4     = 16'h0800;
    localparam logic [15:0] ETH_IPV6     = 16'h86DD;
    localparam logic [7:0]  PROTO_ICMP   = 8'd1;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;
    localparam logic [7:0]  PROTO_ICMPV6 = 8'd58;

    // Verdict codes.
    localparam logic [2:0] V_PASS  = 3'd0;
    localparam logic [2:0] V_DROP  = 3'd1;
    localparam logic [2:0] V_HONEY = 3'd2;
    localparam logic [2:0] V_SOCK  = 3'd3;
    localparam logic [2:0] V_ABORT = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_WINDOW    = 1'b1;

    // Register reset values.
    localparam logic [15:0] THRESHOLD_RST = 16'd20;
    localparam logic [63:0] WINDOW_RST    = 64'd300000000000;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    // A lookup key: family tag and 128-bit source address.
    typedef struct packed {
        logic [1:0]  fam;
        logic [63:0] hi;
        logic [63:0] lo;
    } pfrl_key_t;

    // One rate table entry beside its key.
    typedef struct packed {
        logic        ban;
        logic [31:0] count;
        logic [63:0] stamp;
    } pfrl_rate_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RATE,
        S_RESULT
    } pfrl_state_t;

endpackage

@@ rtl/core/packet_filter_rate_limiter_unit.sv @@
`timescale 1ns / 1ps
// Packet filter with block, watch and fixed-window rate tables.
// Depends on pfrl_pkg, pfrl_key_table and pfrl_rate_store.
//
// Each input beat classifies one packet summary (tuser = 0), loads a source
// into the block (1) or watch (2) table or is ignored (3), and gives exactly
// one output beat. One item is in flight at a time. The three tables are
// searched in parallel, one stored entry per cycle, each up to its fill
// count or a match; an ICMP source already being tracked goes through a
// further rate state (the rate entry is read while the lookups settle, then
// updated). Tables fill from the lowest entry up and need no clearing after
// reset. The output register holds a finished result while the next beat is
// accepted. Configuration writes are always taken.
module packet_filter_rate_limiter_unit
    import pfrl_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
)
(
    input  logic         clk,
    input  logic         rst_n,
    // Input items.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // ether_type[15:0], ip_proto[23:16], header_ok[24], src_addr_hi[88:25],
    // src_addr_lo[152:89], rx_queue[158:153], now_ns[222:159], zero[223]
    input  logic [223:0] s_axis_tdata,
    // action[1:0]
    input  logic [1:0]   s_axis_tuser,
    // Results.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // verdict[2:0], out_queue[8:3], insert_failed[9], zero[15:10]
    output logic [15:0]  m_axis_tdata,
    // Configuration writes.
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [63:0]  cfg_data
);

    pfrl_state_t state_reg, state_next;

    logic [15:0]   thr_reg;
    logic [63:0]   window_reg;

    logic [1:0]    act_reg;
    pfrl_key_t     key_reg;
    pfrl_key_t     key_in;
    logic [7:0]    proto_reg;
    logic          hdr_reg;
    logic [5:0]    queue_reg;
    logic [63:0]   now_reg;

    logic          blk_done, wat_done, rat_done;
    logic          blk_hit, wat_hit, rat_hit;
    logic [AW-1:0] blk_idx, wat_idx, rat_idx;
    logic          blk_full, wat_full, rat_full;
    logic [AW-1:0] blk_fill, wat_fill, rat_fill;

    logic          blk_done_reg, wat_done_reg, rat_done_reg;
    logic          blk_hit_reg, wat_hit_reg, rat_hit_reg;
    logic [AW-1:0] rat_idx_reg;
    logic          all_done;

    logic          in_fire;
    logic          blk_ins, wat_ins, rat_ins;
    logic          go_rate;
    logic          st_wr;
    logic [AW-1:0] st_wr_idx;
    pfrl_rate_t    st_wr_data;
    pfrl_rate_t    st_q;

    logic [2:0]    verdict_c;
    logic [5:0]    queue_c;
    logic          failed_c;
    logic          res_load;
    logic [2:0]    verdict_reg;
    logic [5:0]    oq_reg;
    logic          failed_reg;

    logic          out_valid_reg;
    logic [15:0]   out_data_reg;
    logic          out_load;

    logic [63:0]   age;
    logic          in_window;
    logic [31:0]   cnt0, cnt1;
    logic [63:0]   stamp0;
    logic [7:0]    icmp_proto;
    logic          queue_ok;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign all_done      = blk_done_reg && wat_done_reg && rat_done_reg;

    // Key normalization: IPv4 keeps only the low 32 address bits.
    always_comb
    begin
        key_in.fam = FAM_NONE;
        key_in.hi  = s_axis_tdata[88:25];
        key_in.lo  = s_axis_tdata[152:89];
        if (s_axis_tdata[15:0] == ETH_IPV4)
        begin
            key_in.fam = FAM_IPV4;
            key_in.hi  = '0;
            key_in.lo  = {32'b0, s_axis_tdata[120:89]};
        end
        else if (s_axis_tdata[15:0] == ETH_IPV6)
        begin
            key_in.fam = FAM_IPV6;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= THRESHOLD_RST;
            window_reg <= WINDOW_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD: thr_reg    <= cfg_data[15:0];
                CFG_WINDOW:    window_reg <= cfg_data;
                default:       window_reg <= window_reg;
            endcase
        end
    end

    // Item capture.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            act_reg   <= s_axis_tuser;
            key_reg   <= key_in;
            proto_reg <= s_axis_tdata[23:16];
            hdr_reg   <= s_axis_tdata[24];
            queue_reg <= s_axis_tdata[158:153];
            now_reg   <= s_axis_tdata[222:159];
        end
    end

    // Lookup results, held until the item is decided.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_done_reg <= 1'b0;
            wat_done_reg <= 1'b0;
            rat_done_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            blk_done_reg <= 1'b0;
            wat_done_reg <= 1'b0;
            rat_done_reg <= 1'b0;
        end
        else
        begin
            blk_done_reg <= blk_done_reg || blk_done;
            wat_done_reg <= wat_done_reg || wat_done;
            rat_done_reg <= rat_done_reg || rat_done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (blk_done)
        begin
            blk_hit_reg <= blk_hit;
        end
        if (wat_done)
        begin
            wat_hit_reg <= wat_hit;
        end
        if (rat_done)
        begin
            rat_hit_reg <= rat_hit;
            rat_idx_reg <= rat_idx;
        end
    end

    pfrl_key_table #(.ENTRIES(TABLE_ENTRIES)) u_blk (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_fire),
        .key      (key_reg),
        .insert   (blk_ins),
        .done     (blk_done),
        .hit      (blk_hit),
        .hit_idx  (blk_idx),
        .full     (blk_full),
        .fill_idx (blk_fill)
    );

    pfrl_key_table #(.ENTRIES(TABLE_ENTRIES)) u_wat (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_fire),
        .key      (key_reg),
        .insert   (wat_ins),
        .done     (wat_done),
        .hit      (wat_hit),
        .hit_idx  (wat_idx),
        .full     (wat_full),
        .fill_idx (wat_fill)
    );

    pfrl_key_table #(.ENTRIES(TABLE_ENTRIES)) u_rat (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_fire),
        .key      (key_reg),
        .insert   (rat_ins),
        .done     (rat_done),
        .hit      (rat_hit),
        .hit_idx  (rat_idx),
        .full     (rat_full),
        .fill_idx (rat_fill)
    );

    pfrl_rate_store #(.ENTRIES(TABLE_ENTRIES)) u_store (
        .clk     (clk),
        .rd_idx  (rat_idx_reg),
        .wr_en   (st_wr),
        .wr_idx  (st_wr_idx),
        .wr_data (st_wr_data),
        .rd_data (st_q)
    );

    // Window arithmetic on the rate entry just read.
    assign age       = now_reg - st_q.stamp;
    assign in_window = (age <= window_reg);
    assign cnt0      = in_window ? st_q.count : '0;
    assign stamp0    = in_window ? st_q.stamp : now_reg;
    assign cnt1      = (cnt0 == COUNT_MAX) ? cnt0 : cnt0 + 32'd1;

    assign icmp_proto = (key_reg.fam == FAM_IPV4) ? PROTO_ICMP : PROTO_ICMPV6;
    assign queue_ok   = ({1'b0, queue_reg} < 7'(QUEUE_COUNT));

    // Decision logic and table writes.
    always_comb
    begin
        verdict_c  = V_PASS;
        queue_c    = '0;
        failed_c   = 1'b0;
        res_load   = 1'b0;
        go_rate    = 1'b0;
        blk_ins    = 1'b0;
        wat_ins    = 1'b0;
        rat_ins    = 1'b0;
        st_wr      = 1'b0;
        st_wr_idx  = rat_fill;
        st_wr_data = '{ban: 1'b0, count: 32'd1, stamp: now_reg};
        out_load   = 1'b0;
        unique case (state_reg)
            S_SCAN:
            begin
                if (all_done)
                begin
                    res_load = 1'b1;
                    if (key_reg.fam == FAM_NONE)
                    begin
                        verdict_c = V_PASS;
                    end
                    else if (act_reg == ACT_BLOCK)
                    begin
                        failed_c = !blk_hit_reg && blk_full;
                        blk_ins  = !blk_hit_reg;
                    end
                    else if (act_reg == ACT_WATCH)
                    begin
                        failed_c = !wat_hit_reg && wat_full;
                        wat_ins  = !wat_hit_reg;
                    end
                    else if (act_reg == ACT_CLASSIFY)
                    begin
                        priority if (!hdr_reg)
                        begin
                            verdict_c = V_ABORT;
                        end
                        else if (blk_hit_reg)
                        begin
                            verdict_c = V_DROP;
                        end
                        else if (wat_hit_reg)
                        begin
                            verdict_c = V_HONEY;
                        end
                        else if (proto_reg == icmp_proto)
                        begin
                            if (rat_hit_reg)
                            begin
                                res_load = 1'b0;
                                go_rate  = 1'b1;
                            end
                            else
                            begin
                                failed_c = rat_full;
                                rat_ins  = 1'b1;
                                st_wr    = !rat_full;
                            end
                        end
                        else if (proto_reg == PROTO_TCP || proto_reg == PROTO_UDP)
                        begin
                            verdict_c = queue_ok ? V_SOCK : V_ABORT;
                            queue_c   = queue_ok ? queue_reg : '0;
                        end
                        else
                        begin
                            verdict_c = V_PASS;
                        end
                    end
                end
            end
            S_RATE:
            begin
                res_load  = 1'b1;
                st_wr     = 1'b1;
                st_wr_idx = rat_idx_reg;
                priority if (st_q.ban)
                begin
                    verdict_c = V_DROP;
                    st_wr     = 1'b0;
                end
                else if (in_window && (st_q.count >= {16'b0, thr_reg}))
                begin
                    verdict_c  = V_DROP;
                    st_wr_data = '{ban: 1'b1, count: st_q.count, stamp: st_q.stamp};
                end
                else
                begin
                    verdict_c  = V_PASS;
                    st_wr_data = '{ban: 1'b0, count: cnt1,
                                   stamp: (cnt1 == {16'b0, thr_reg}) ? now_reg : stamp0};
                end
            end
            S_RESULT:
            begin
                out_load = !out_valid_reg || m_axis_tready;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (go_rate)
                begin
                    state_next = S_RATE;
                end
                else if (all_done)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RATE:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Result held until the output register is free.
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            verdict_reg <= verdict_c;
            oq_reg      <= queue_c;
            failed_reg  <= failed_c;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {6'b0, failed_reg, oq_reg, verdict_reg};
        end
    end

endmodule

@@ rtl/core/pfrl_key_table.sv @@
`timescale 1ns / 1ps
// Key table: a synchronous memory of source keys filled from the bottom,
// searched one entry per cycle. Depends on pfrl_pkg.
module pfrl_key_table
    import pfrl_pkg::*;
#(
    parameter int unsigned ENTRIES = TABLE_ENTRIES_DEF,
    localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int unsigned CW = $clog2(ENTRIES + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  pfrl_key_t     key,
    input  logic          insert,
    output logic          done,
    output logic          hit,
    output logic [AW-1:0] hit_idx,
    output logic          full,
    output logic [AW-1:0] fill_idx
);

    pfrl_key_t     mem [ENTRIES];
    pfrl_key_t     mem_q_reg;
    logic          scan_reg;
    logic [CW-1:0] addr_reg;
    logic          cmp_valid_reg;
    logic [AW-1:0] cmp_idx_reg;
    logic [CW-1:0] fill_reg;
    logic          match;
    logic          finish;
    logic          issue;

    // Entries below the fill count are all valid, so no tags are kept.
    assign match  = cmp_valid_reg && (mem_q_reg == key);
    assign finish = scan_reg && (match || (addr_reg == fill_reg));
    assign issue  = scan_reg && !finish;

    assign done     = finish;
    assign hit      = match;
    assign hit_idx  = cmp_idx_reg;
    assign full     = (fill_reg == CW'(ENTRIES));
    assign fill_idx = fill_reg[AW-1:0];

    // Scan control: one read issued and one compare made per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg      <= 1'b0;
            addr_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            fill_reg      <= '0;
        end
        else
        begin
            if (start)
            begin
                scan_reg      <= 1'b1;
                addr_reg      <= '0;
                cmp_valid_reg <= 1'b0;
            end
            else if (issue)
            begin
                addr_reg      <= addr_reg + 1'b1;
                cmp_valid_reg <= 1'b1;
            end
            else
            begin
                scan_reg      <= 1'b0;
                cmp_valid_reg <= 1'b0;
            end
            if (insert && !full)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    // Index of the entry whose data comes back next cycle.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            cmp_idx_reg <= addr_reg[AW-1:0];
        end
    end

    // Key memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (insert && !full)
        begin
            mem[fill_reg[AW-1:0]] <= key;
        end
        mem_q_reg <= mem[addr_reg[AW-1:0]];
    end

endmodule

@@ rtl/core/pfrl_rate_store.sv @@
`timescale 1ns / 1ps
// Rate store: count, window stamp and ban flag per rate table entry,
// held in one synchronous memory. Depends on pfrl_pkg.
module pfrl_rate_store
    import pfrl_pkg::*;
#(
    parameter int unsigned ENTRIES = TABLE_ENTRIES_DEF,
    localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
)
(
    input  logic          clk,
    input  logic [AW-1:0] rd_idx,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_idx,
    input  pfrl_rate_t    wr_data,
    output pfrl_rate_t    rd_data
);

    pfrl_rate_t mem [ENTRIES];
    pfrl_rate_t rd_data_reg;

    assign rd_data = rd_data_reg;

    // Read is registered; the sequencer writes before it reads again.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        rd_data_reg <= mem[rd_idx];
    end

endmodule
